FILE: rtl/core/prre_pkg.sv
// shared types and constants of the partitioned rice residual encoder
`default_nettype none
package prre_pkg;

    // header field layout
    localparam int PARAM_FIELD_BITS = 4;
    localparam int RAW_FIELD_BITS   = 5;
    localparam int ESCAPE_CODE      = 15;

    // fixed field widths
    localparam int RESIDUAL_W  = 32;
    localparam int PARAM_W     = 4;
    localparam int WIDTH_W     = 5;
    localparam int RUN_W       = 32;
    localparam int CODE_W      = 31;
    localparam int LEN_W       = 5;
    localparam int COUNT_W     = 16;
    localparam int PORDER_W    = 4;
    localparam int PRED_W      = 6;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 72;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [4:0] ESCAPE_V = 5'(ESCAPE_CODE);
    localparam logic [CODE_W-1:0] PARAM_MASK = CODE_W'((1 << PARAM_FIELD_BITS) - 1);
    localparam logic [CODE_W-1:0] RAW_MASK   = CODE_W'((1 << RAW_FIELD_BITS) - 1);
    localparam logic [CODE_W-1:0] ESC_HDR    =
        CODE_W'((ESCAPE_CODE & ((1 << PARAM_FIELD_BITS) - 1)) << RAW_FIELD_BITS);
    localparam logic [LEN_W-1:0] HDR_LEN     = LEN_W'(PARAM_FIELD_BITS);
    localparam logic [LEN_W-1:0] ESC_HDR_LEN = LEN_W'(PARAM_FIELD_BITS + RAW_FIELD_BITS);
    localparam logic [COUNT_W-1:0] BLOCK_SIZE_RESET = 16'd4096;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PARTITION_ORDER = 2'd0,
        CFG_PREDICTOR_ORDER = 2'd1,
        CFG_BLOCK_SIZE      = 2'd2
    } prre_cfg_idx_t;

    // one classified item: header count and header, then the sample chunk
    typedef struct packed {
        logic [1:0]        nhdr;
        logic [CODE_W-1:0] hdr_value;
        logic [LEN_W-1:0]  hdr_len;
        logic [RUN_W-1:0]  zero_run;
        logic [CODE_W-1:0] code_value;
        logic [LEN_W-1:0]  code_len;
        logic              eob;
    } prre_entry_t;

    // queue status toward the back end
    typedef struct packed {
        logic        empty;
        prre_entry_t head;
    } prre_qhead_t;

endpackage
`default_nettype wire

FILE: rtl/core/prre_front.sv
// front end: partition tracking, header decision and sample code forming
`default_nettype none
module prre_front
    import prre_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    input  wire logic [RESIDUAL_W-1:0]  in_residual,
    input  wire logic [PARAM_W-1:0]     in_param,
    input  wire logic [WIDTH_W-1:0]     in_width,
    input  wire logic                   q_full,
    output logic                        in_ready,
    output logic                        push,
    output prre_entry_t                 push_entry
);

    logic [PORDER_W-1:0] porder_reg;
    logic [PRED_W-1:0]   pred_reg;
    logic [COUNT_W-1:0]  bsize_reg;

    logic [COUNT_W-1:0] left_reg, left_next;
    logic [COUNT_W-1:0] idx_reg, idx_next;
    logic [PARAM_W-1:0] hparam_reg, hparam_next;
    logic [WIDTH_W-1:0] hwidth_reg, hwidth_next;

    logic               start;
    logic [COUNT_W-1:0] dflt;
    logic [COUNT_W-1:0] idx_eff;
    logic [COUNT_W-1:0] len0;
    logic               empty_first;
    logic [COUNT_W-1:0] idx_base;
    logic [COUNT_W-1:0] len_start;
    logic [COUNT_W-1:0] left_cur;
    logic [COUNT_W-1:0] left_dec;
    logic [COUNT_W:0]   idx_inc;
    logic               last_part;
    logic               eob;
    logic               esc_in;
    logic               esc_held;
    logic [31:0]        uval;
    logic [31:0]        kmask;
    logic [31:0]        wmask;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            porder_reg <= '0;
            pred_reg   <= '0;
            bsize_reg  <= BLOCK_SIZE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PARTITION_ORDER: porder_reg <= cfg_data[PORDER_W-1:0];
                CFG_PREDICTOR_ORDER: pred_reg   <= cfg_data[PRED_W-1:0];
                CFG_BLOCK_SIZE:      bsize_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        start   = (left_reg == '0);
        dflt    = bsize_reg >> porder_reg;
        // index past the partition count starts a new block
        idx_eff = ((idx_reg >> porder_reg) != '0) ? '0 : idx_reg;
        len0    = (dflt > {{(COUNT_W-PRED_W){1'b0}}, pred_reg}) ?
                  dflt - {{(COUNT_W-PRED_W){1'b0}}, pred_reg} : '0;
        if (idx_eff != '0) begin
            len0 = dflt;
        end
        // first partition eaten by warm-up: its header goes out with the next one
        empty_first = (idx_eff == '0) && (len0 == '0) && (porder_reg != '0) && (dflt != '0);
        len_start   = empty_first ? dflt : len0;
        if (len_start == '0) begin
            len_start = COUNT_W'(1);
        end

        idx_base    = start ? (empty_first ? COUNT_W'(1) : idx_eff) : idx_reg;
        left_cur    = start ? len_start : left_reg;
        hparam_next = start ? in_param : hparam_reg;
        hwidth_next = start ? in_width : hwidth_reg;

        left_dec  = left_cur - COUNT_W'(1);
        idx_inc   = {1'b0, idx_base} + (COUNT_W+1)'(1);
        last_part = (idx_inc >> porder_reg) != '0;
        eob       = (left_dec == '0) && last_part;
        left_next = left_dec;
        if (left_dec == '0) begin
            idx_next = last_part ? '0 : idx_inc[COUNT_W-1:0];
        end else begin
            idx_next = idx_base;
        end

        esc_in = {1'b0, in_param} >= ESCAPE_V;
        push_entry.nhdr = start ? (empty_first ? 2'd2 : 2'd1) : 2'd0;
        if (esc_in) begin
            push_entry.hdr_value = ESC_HDR | (CODE_W'(in_width) & RAW_MASK);
            push_entry.hdr_len   = ESC_HDR_LEN;
        end else begin
            push_entry.hdr_value = CODE_W'(in_param) & PARAM_MASK;
            push_entry.hdr_len   = HDR_LEN;
        end

        // zigzag map and rice split, or raw two's complement
        esc_held = {1'b0, hparam_next} >= ESCAPE_V;
        uval  = {in_residual[RESIDUAL_W-2:0], 1'b0} ^ {RESIDUAL_W{in_residual[RESIDUAL_W-1]}};
        kmask = (32'd1 << hparam_next) - 32'd1;
        wmask = (32'd1 << hwidth_next) - 32'd1;
        if (esc_held) begin
            push_entry.zero_run   = '0;
            push_entry.code_value = in_residual[CODE_W-1:0] & wmask[CODE_W-1:0];
            push_entry.code_len   = hwidth_next;
        end else begin
            push_entry.zero_run   = uval >> hparam_next;
            push_entry.code_value = CODE_W'((32'd1 << hparam_next) | (uval & kmask));
            push_entry.code_len   = LEN_W'(hparam_next) + LEN_W'(1);
        end
        push_entry.eob = eob;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg   <= '0;
            idx_reg    <= '0;
            hparam_reg <= '0;
            hwidth_reg <= '0;
        end else if (push) begin
            left_reg   <= left_next;
            idx_reg    <= idx_next;
            hparam_reg <= hparam_next;
            hwidth_reg <= hwidth_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/prre_queue.sv
// short item queue between front and back end
`default_nettype none
module prre_queue
    import prre_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  wire prre_entry_t push_entry,
    input  wire logic        pop,
    output logic             full,
    output prre_qhead_t      qhead
);

    prre_entry_t        mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign full        = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign qhead.empty = (count_reg == '0);
    assign qhead.head  = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/prre_back.sv
// back end: splits each item into header and sample chunks, output register
`default_nettype none
module prre_back
    import prre_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire prre_qhead_t           qhead,
    output logic                       pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,
    output logic                       m_tlast,
    output logic                       m_tuser
);

    logic [1:0]        hdr_cnt_reg, hdr_cnt_next;
    logic              valid_reg, valid_next;
    logic [RUN_W-1:0]  run_reg, run_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              last_reg, last_next;
    logic              eob_reg, eob_next;
    logic              load;
    logic              send_hdr;

    assign load     = !valid_reg || m_tready;
    assign send_hdr = hdr_cnt_reg < qhead.head.nhdr;
    assign pop      = load && !qhead.empty && !send_hdr;

    always_comb begin
        hdr_cnt_next = hdr_cnt_reg;
        valid_next   = valid_reg;
        run_next     = run_reg;
        code_next    = code_reg;
        len_next     = len_reg;
        last_next    = last_reg;
        eob_next     = eob_reg;
        if (load) begin
            valid_next = !qhead.empty;
            if (!qhead.empty) begin
                if (send_hdr) begin
                    hdr_cnt_next = hdr_cnt_reg + 2'd1;
                    run_next     = '0;
                    code_next    = qhead.head.hdr_value;
                    len_next     = qhead.head.hdr_len;
                    last_next    = 1'b0;
                    eob_next     = 1'b0;
                end else begin
                    hdr_cnt_next = '0;
                    run_next     = qhead.head.zero_run;
                    code_next    = qhead.head.code_value;
                    len_next     = qhead.head.code_len;
                    last_next    = 1'b1;
                    eob_next     = qhead.head.eob;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_cnt_reg <= '0;
            valid_reg   <= 1'b0;
        end else begin
            hdr_cnt_reg <= hdr_cnt_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        run_reg  <= run_next;
        code_reg <= code_next;
        len_reg  <= len_next;
        last_reg <= last_next;
        eob_reg  <= eob_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(M_TDATA_W-RUN_W-CODE_W-LEN_W){1'b0}}, len_reg, code_reg, run_reg};
    assign m_tlast  = eob_reg;
    assign m_tuser  = last_reg;

endmodule
`default_nettype wire

FILE: rtl/core/partitioned_rice_residual_encoder_top.sv
// Partitioned Rice residual encoder: one signed residual in per beat, bit-stream
// chunks out. Each result beat asks the packer for zero_run zero bits followed by
// the code_len low bits of code_value, most significant first.
// Input beat s_tdata: residual[31:0], rice_param[35:32], raw_width[40:36].
// Result beat m_tdata: zero_run[31:0], code_value[62:32], code_len[67:63];
// m_tuser marks the last chunk of an input beat, m_tlast the end of a block.
// Configuration (partition order, predictor order, block size) is written through
// cfg_we/cfg_index/cfg_data while the block is idle.
// Timing: a residual enters every cycle while s_tready is high; the front end
// classifies it in that cycle and writes a four-entry queue; from it the back end
// loads the output register with one chunk per cycle unless m_tready stalls. A
// sample that opens a partition adds one header chunk (two when the first
// partition is empty), so such a beat yields two or three chunks; the output chunk
// rate of one per cycle is the limit, and the queue absorbs those extra chunks.
// When m_tready is low the output register holds; once the queue fills, s_tready
// drops. Reset empties the queue, drops m_tvalid, clears partition tracking and
// restores the block size to 4096.
`default_nettype none
module partitioned_rice_residual_encoder_top
    import prre_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,   // residual, rice_param, raw_width
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [M_TDATA_W-1:0]        m_tdata,   // zero_run, code_value, code_len
    output logic                        m_tlast,
    output logic                        m_tuser    // last_of_item
);

    logic        q_full;
    logic        push;
    logic        pop;
    prre_entry_t push_entry;
    prre_qhead_t qhead;

    prre_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (s_tvalid),
        .in_residual (s_tdata[RESIDUAL_W-1:0]),
        .in_param    (s_tdata[RESIDUAL_W +: PARAM_W]),
        .in_width    (s_tdata[RESIDUAL_W+PARAM_W +: WIDTH_W]),
        .q_full      (q_full),
        .in_ready    (s_tready),
        .push        (push),
        .push_entry  (push_entry)
    );

    prre_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .qhead      (qhead)
    );

    prre_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .qhead    (qhead),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

FILE: rtl/core/prre_checker.sv
// port-level checks of the encoder, bound to the top level
`default_nettype none
module prre_checker
    import prre_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic                 m_tlast,
    input wire logic                 m_tuser
);

    // output stays empty right after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // block end only on a sample chunk
    a_eob_on_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("end of block on a header chunk");

    // header chunks carry no zero run and either the plain or the escape header length
    a_header_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[RUN_W-1:0] == '0 &&
            (m_tdata[RUN_W+CODE_W +: LEN_W] == HDR_LEN ||
             m_tdata[RUN_W+CODE_W +: LEN_W] == ESC_HDR_LEN))
        else $error("malformed header chunk");

endmodule

bind partitioned_rice_residual_encoder_top prre_checker u_prre_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
`default_nettype wire

FILE: dv/prre_stream_checker.sv
// stream checker for the partitioned rice residual encoder: predicts and compares result beats
`timescale 1ns / 100ps
module prre_stream_checker
    import prre_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,   // residual, rice_param, raw_width
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [M_TDATA_W-1:0]   m_tdata,   // zero_run, code_value, code_len
    input  wire logic                   m_tlast,
    input  wire logic                   m_tuser,   // last_of_item
    output int                          mismatches,
    output int                          chunks_waiting,
    output int                          chunks_matched
);

    typedef struct packed {
        logic [RUN_W-1:0]  zero_run;
        logic [CODE_W-1:0] code_value;
        logic [LEN_W-1:0]  code_len;
        logic              last_of_item;
        logic              end_of_block;
    } chunk_t;

    chunk_t expected_chunks[$];

    // register copies
    logic [PORDER_W-1:0] part_order = '0;
    logic [PRED_W-1:0]   pred_order = '0;
    logic [COUNT_W-1:0]  block_size = 16'd4096;

    // partition tracking
    logic [COUNT_W-1:0]  samples_left    = '0;
    logic [31:0]         partition_index = '0;
    logic [PARAM_W-1:0]  held_param      = '0;
    logic [WIDTH_W-1:0]  held_width      = '0;

    initial begin
        mismatches     = 0;
        chunks_waiting = 0;
        chunks_matched = 0;
    end

    function automatic logic [31:0] low_ones(input int unsigned bits);
        return (bits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 32'd1);
    endfunction

    function automatic chunk_t header_chunk(input logic [PARAM_W-1:0] param,
                                            input logic [WIDTH_W-1:0] width);
        chunk_t c;
        c = '0;
        if (param >= ESCAPE_CODE) begin
            // escape code on top, raw width below it
            c.code_value = CODE_W'(((ESCAPE_CODE & ((1 << PARAM_FIELD_BITS) - 1))
                                    << RAW_FIELD_BITS)
                                   | (32'(width) & low_ones(RAW_FIELD_BITS)));
            c.code_len   = LEN_W'(PARAM_FIELD_BITS + RAW_FIELD_BITS);
        end else begin
            c.code_value = CODE_W'(32'(param) & low_ones(PARAM_FIELD_BITS));
            c.code_len   = LEN_W'(PARAM_FIELD_BITS);
        end
        return c;
    endfunction

    task automatic encode_residual(input logic [31:0] res,
                                   input logic [PARAM_W-1:0] param,
                                   input logic [WIDTH_W-1:0] width);
        logic [31:0] pcount;
        logic [31:0] dflt;
        logic [31:0] len;
        logic [31:0] uval;
        logic [31:0] code;
        int unsigned k;
        logic        eob;
        chunk_t      c;
        pcount = 32'd1 << part_order;
        dflt   = 32'(block_size) >> part_order;
        eob    = 1'b0;
        if (samples_left == '0) begin
            if (partition_index >= pcount)
                partition_index = '0;
            if (partition_index == '0)
                len = (dflt > 32'(pred_order)) ? dflt - 32'(pred_order) : '0;
            else
                len = dflt;
            // first partition swallowed by warm-up: its header goes out anyway
            if (partition_index == '0 && len == '0 && pcount > 32'd1 && dflt >= 32'd1) begin
                expected_chunks.push_back(header_chunk(param, width));
                partition_index = 32'd1;
                len = dflt;
            end
            if (len == '0)
                len = 32'd1;
            expected_chunks.push_back(header_chunk(param, width));
            held_param   = param;
            held_width   = width;
            samples_left = len[COUNT_W-1:0];
        end
        samples_left = samples_left - COUNT_W'(1);
        if (samples_left == '0) begin
            if (partition_index + 32'd1 >= pcount) begin
                eob = 1'b1;
                partition_index = '0;
            end else begin
                partition_index = partition_index + 32'd1;
            end
        end
        c = '0;
        c.last_of_item = 1'b1;
        c.end_of_block = eob;
        if (held_param >= ESCAPE_CODE) begin
            c.code_value = CODE_W'(res & low_ones(held_width));
            c.code_len   = LEN_W'(held_width);
        end else begin
            k = held_param;
            // zigzag: 0,-1,1,-2 -> 0,1,2,3
            uval = {res[30:0], 1'b0} ^ {32{res[31]}};
            code = (32'd1 << k) | (uval & low_ones(k));
            c.zero_run   = uval >> k;
            c.code_value = CODE_W'(code);
            c.code_len   = LEN_W'(k + 1);
        end
        expected_chunks.push_back(c);
    endtask

    function automatic string show(input chunk_t c);
        return $sformatf("run %0d value %h len %0d last %0b eob %0b",
                         c.zero_run, c.code_value, c.code_len, c.last_of_item,
                         c.end_of_block);
    endfunction

    always @(posedge aclk) begin : watch
        chunk_t got;
        chunk_t want;
        if (!aresetn) begin
            part_order      = '0;
            pred_order      = '0;
            block_size      = 16'd4096;
            samples_left    = '0;
            partition_index = '0;
            held_param      = '0;
            held_width      = '0;
            expected_chunks.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_PARTITION_ORDER: part_order = cfg_data[PORDER_W-1:0];
                    CFG_PREDICTOR_ORDER: pred_order = cfg_data[PRED_W-1:0];
                    CFG_BLOCK_SIZE:      block_size = cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                encode_residual(s_tdata[31:0], s_tdata[35:32], s_tdata[40:36]);
            if (m_tvalid && m_tready) begin
                got.zero_run     = m_tdata[31:0];
                got.code_value   = m_tdata[62:32];
                got.code_len     = m_tdata[67:63];
                got.last_of_item = m_tuser;
                got.end_of_block = m_tlast;
                if (expected_chunks.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected chunk: %s", $realtime, show(got));
                end else begin
                    want = expected_chunks.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: chunk mismatch\n  expected %s\n  actual   %s",
                                     $realtime, show(want), show(got));
                    end else begin
                        chunks_matched++;
                    end
                end
            end
        end
        chunks_waiting = expected_chunks.size();
    end

endmodule

FILE: dv/tb_partitioned_rice_residual_encoder_top.sv
// testbench top for the partitioned rice residual encoder: stimulus, stalls and verdict
`timescale 1ns / 100ps
module tb_partitioned_rice_residual_encoder_top;
    import prre_pkg::*;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    prre_cfg_idx_t         cfg_index = CFG_PARTITION_ORDER;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tready  = 1'b0;
    wire                   s_tready;
    wire                   m_tvalid;
    wire [M_TDATA_W-1:0]   m_tdata;
    wire                   m_tlast;
    wire                   m_tuser;

    int mismatches;
    int chunks_waiting;
    int chunks_matched;

    int   residuals_sent = 0;
    int   settings_used  = 0;
    logic calm           = 1'b0;
    logic hold_request   = 1'b0;

    // four partitions of two samples, the first shortened to one by warm-up
    logic [31:0] directed_residual [20] = '{
        32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h1234_5678,
        32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_8000, 32'h0001_7FFF,
        32'hFFFF_FFFB, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 32'h0000_0001,
        32'hFFFF_FFFF, 32'h0000_0002, 32'h0000_0000, 32'hFFFF_C000, 32'h0000_0003};
    logic [PARAM_W-1:0] directed_param [20] = '{
        4'd0, 4'd14, 4'd9, 4'd15, 4'd3, 4'd15, 4'd0, 4'd1, 4'd15, 4'd6,
        4'd7, 4'd15, 4'd3, 4'd12, 4'd15, 4'd0, 4'd5, 4'd14, 4'd15, 4'd2};
    logic [WIDTH_W-1:0] directed_width [20] = '{
        5'd0, 5'd31, 5'd7, 5'd0, 5'd19, 5'd31, 5'd2, 5'd0, 5'd16, 5'd4,
        5'd10, 5'd21, 5'd0, 5'd8, 5'd1, 5'd31, 5'd11, 5'd0, 5'd26, 5'd5};

    partitioned_rice_residual_encoder_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // residual, rice_param, raw_width
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // zero_run, code_value, code_len
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)     // last_of_item
    );

    prre_stream_checker u_stream_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser),
        .mismatches    (mismatches),
        .chunks_waiting(chunks_waiting),
        .chunks_matched(chunks_matched)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic logic [31:0] pick_residual();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 128) - 64;
            1: return r;
            2: return {{16{r[15]}}, r[15:0]};
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'h0000_0000;
                    1: return 32'hFFFF_FFFF;
                    2: return 32'h7FFF_FFFF;
                    default: return 32'h8000_0000;
                endcase
            end
        endcase
    endfunction

    function automatic logic [PARAM_W-1:0] pick_param();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return PARAM_W'($urandom_range(0, 4));
        else if (r < 6)
            return PARAM_W'(ESCAPE_CODE);
        else
            return PARAM_W'($urandom_range(0, 14));
    endfunction

    // writes all three registers on consecutive edges; block must be idle
    task automatic apply_settings(input logic [PORDER_W-1:0] order,
                                  input logic [PRED_W-1:0] pred,
                                  input logic [COUNT_W-1:0] size);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PARTITION_ORDER;
        cfg_data  <= CFG_DATA_W'(order);
        @(posedge aclk);
        cfg_index <= CFG_PREDICTOR_ORDER;
        cfg_data  <= CFG_DATA_W'(pred);
        @(posedge aclk);
        cfg_index <= CFG_BLOCK_SIZE;
        cfg_data  <= size;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    task automatic send_residual(input logic [31:0] res, input logic [PARAM_W-1:0] param,
                                 input logic [WIDTH_W-1:0] width);
        if (!calm && $urandom_range(0, 6) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, width, param, res};
        // ready seen at the falling edge means the beat goes at the next rising edge
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        residuals_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (chunks_waiting != 0);
        repeat (6) @(posedge aclk);
    endtask

    task automatic run_batch(input logic [PORDER_W-1:0] order, input logic [PRED_W-1:0] pred,
                             input logic [COUNT_W-1:0] size, input int count);
        apply_settings(order, pred, size);
        repeat (count) send_residual(pick_residual(), pick_param(), WIDTH_W'($urandom()));
        drain();
    endtask

    // result side: random stall bursts, one long hold on request
    initial begin
        wait (aresetn === 1'b1);
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (90) @(posedge aclk);
                hold_request = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    end

    initial begin
        #400000;
        $display("run timed out with %0d chunks outstanding", chunks_waiting);
        $display("partitioned_rice_residual_encoder_top verification failed");
        $finish;
    end

    initial begin
        logic [PORDER_W-1:0] order;
        logic [PRED_W-1:0]   pred;
        logic [COUNT_W-1:0]  size;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset register values: one long partition
        repeat (6) send_residual(pick_residual(), pick_param(), WIDTH_W'($urandom()));
        drain();

        apply_settings(4'd2, 6'd1, 16'd8);
        for (int i = 0; i < 20; i++)
            send_residual(directed_residual[i], directed_param[i], directed_width[i]);
        drain();

        run_batch(4'd2, 6'd8, 16'd16, 24);      // warm-up covers the first partition
        run_batch(4'd0, 6'd32, 16'd5, 12);      // single partition shorter than warm-up
        run_batch(4'd4, 6'd0, 16'd3, 12);       // partition length shifts to zero
        hold_request = 1'b1;
        run_batch(4'd15, 6'd0, 16'd65535, 40);  // one sample per partition
        run_batch(4'd0, 6'd0, 16'd1, 12);
        run_batch(4'd3, 6'd32, 16'd64, 30);
        run_batch(4'd15, 6'd32, 16'd65535, 16);
        run_batch(4'd0, 6'd0, 16'd65535, 20);   // left mid-block for the next setting

        while (residuals_sent < 410) begin
            order = PORDER_W'($urandom_range(0, 6));
            pred  = ($urandom_range(0, 3) == 0) ? 6'd32 : PRED_W'($urandom_range(0, 10));
            size  = ($urandom_range(0, 5) == 0) ? COUNT_W'($urandom_range(1, 65535))
                                                : COUNT_W'($urandom_range(1, 80));
            run_batch(order, pred, size, $urandom_range(10, 30));
        end

        calm = 1'b1;
        run_batch(4'd1, 6'd2, 16'd12, 50);

        $display("covered %0d residual beats under %0d register settings, %0d chunks checked",
                 residuals_sent, settings_used, chunks_matched);
        $display("included escapes, empty and zero-length partitions and a long output stall");
        if (mismatches == 0 && chunks_waiting == 0)
            $display("partitioned_rice_residual_encoder_top verification clean");
        else
            $display("partitioned_rice_residual_encoder_top verification failed");
        $finish;
    end

endmodule
